// ===== src/texture_texel_to_rgba32_defines.svh =====
// ----------------------------------------------------------------------------
// texture_texel_to_rgba32 assertion macros
// Concurrent assertion helpers, clocked on clock and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_TEXEL_TO_RGBA32_DEFINES_SVH
`define TEXTURE_TEXEL_TO_RGBA32_DEFINES_SVH
`ifndef SYNTHESIS
`define TT2R_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("tt2r assertion failed");
`define TT2R_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tt2r assertion failed");
`define TT2R_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tt2r assertion failed");
`else
`define TT2R_ASSERT(name, prop)
`define TT2R_ASSERT_IMP(name, ante, cons)
`define TT2R_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== src/tt2r_pkg.sv =====
// ----------------------------------------------------------------------------
// tt2r_pkg
// Types and codes shared by the texel to RGBA32 decoder.
// ----------------------------------------------------------------------------
package tt2r_pkg;

   localparam logic [3:0] FMT_I4         = 4'd0;
   localparam logic [3:0] FMT_IA4        = 4'd1;
   localparam logic [3:0] FMT_I8         = 4'd2;
   localparam logic [3:0] FMT_IA8        = 4'd3;
   localparam logic [3:0] FMT_IA16       = 4'd4;
   localparam logic [3:0] FMT_RGBA16     = 4'd5;
   localparam logic [3:0] FMT_RGBA32     = 4'd6;
   localparam logic [3:0] FMT_CI4_RGBA16 = 4'd7;
   localparam logic [3:0] FMT_CI4_IA16   = 4'd8;
   localparam logic [3:0] FMT_CI8_RGBA16 = 4'd9;
   localparam logic [3:0] FMT_CI8_IA16   = 4'd10;

   localparam logic CSR_TEXTURE_FORMAT  = 1'b0;
   localparam logic CSR_PALETTE_ENTRIES = 1'b1;

   localparam logic CMD_PALETTE_WRITE = 1'b0;
   localparam logic CMD_DECODE_WORD   = 1'b1;

   typedef struct packed {
      logic        command;
      logic [7:0]  palette_index;
      logic [15:0] palette_color;
      logic [31:0] pixel_word;
      logic [3:0]  texel_count;
      logic        end_of_image;
   } req_type;

   typedef struct packed {
      logic [31:0] rgba_color;
      logic        bad_index;
      logic        last_of_word;
      logic        image_done;
   } rsp_type;

   // one texel on its way from the unpacker to the converter
   typedef struct packed {
      logic [3:0]  fmt;
      logic        bad;
      logic [31:0] texel;
   } texel_type;

endpackage

// ===== src/texture_texel_to_rgba32.sv =====
// ----------------------------------------------------------------------------
// texture_texel_to_rgba32
// Unpacks texture words and decodes each texel to an RGBA32 pixel.
// ----------------------------------------------------------------------------
// A decode request yields one pixel per cycle, unless the output stalls, for
// each valid texel of the word (0 to 8; eight for a full 4-bpp word), and the
// next request is taken in the cycle its last texel issues. A palette write
// yields nothing. The unpacker issues one texel a cycle, unless the output
// stalls, to the single palette read port; stage one and then the response
// register hold each pixel. The palette needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "texture_texel_to_rgba32_defines.svh"

module texture_texel_to_rgba32 #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tt2r_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tt2r_pkg::rsp_type   rsp_data,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [8:0]          csr_wr_data
);

   localparam int PAW = $clog2(PALETTE_DEPTH);
   localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

   logic [3:0]  fmt_ff;
   logic [8:0]  entries_ff;

   logic        busy_ff, busy_in;
   logic [31:0] word_ff, word_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        eoi_ff, eoi_in;

   logic                  s1_valid_ff;
   tt2r_pkg::texel_type   s1_ff, s1_in;
   logic                  s1_last_ff, s1_done_ff;
   logic [15:0]           rd_ff;

   logic                  rsp_valid_ff;
   tt2r_pkg::rsp_type     rsp_ff;

   logic [15:0] palette_mem [PALETTE_DEPTH];

   logic        adv;
   logic        issue;
   logic        accept;
   logic        last_issue;
   logic [2:0]  bpp_sel;     // encoded class: 0 4bpp, 1 8bpp, 2 16bpp, 3 32bpp
   logic        fmt_ok;
   logic        indexed;
   logic [3:0]  per_word;
   logic [3:0]  cnt_load;
   logic [8:0]  limit;
   logic [7:0]  tidx;
   logic [31:0] rgba;

   assign adv        = !(rsp_valid_ff && rsp_stall);
   assign issue      = busy_ff && adv;
   assign last_issue = issue && (cnt_ff == 4'd1);
   assign req_stall  = busy_ff && !last_issue;
   assign accept     = req_valid && !req_stall;

   always_comb begin
      fmt_ok  = 1'b1;
      indexed = 1'b0;
      bpp_sel = 3'd0;
      case (fmt_ff)
         tt2r_pkg::FMT_I4, tt2r_pkg::FMT_IA4: begin
            bpp_sel = 3'd0;
         end
         tt2r_pkg::FMT_I8, tt2r_pkg::FMT_IA8: begin
            bpp_sel = 3'd1;
         end
         tt2r_pkg::FMT_IA16, tt2r_pkg::FMT_RGBA16: begin
            bpp_sel = 3'd2;
         end
         tt2r_pkg::FMT_RGBA32: begin
            bpp_sel = 3'd3;
         end
         tt2r_pkg::FMT_CI4_RGBA16, tt2r_pkg::FMT_CI4_IA16: begin
            bpp_sel = 3'd0;
            indexed = 1'b1;
         end
         tt2r_pkg::FMT_CI8_RGBA16, tt2r_pkg::FMT_CI8_IA16: begin
            bpp_sel = 3'd1;
            indexed = 1'b1;
         end
         default: begin
            fmt_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (bpp_sel)
         3'd0: per_word = 4'd8;
         3'd1: per_word = 4'd4;
         3'd2: per_word = 4'd2;
         default: per_word = 4'd1;
      endcase
      cnt_load = (req_data.texel_count > per_word) ? per_word : req_data.texel_count;
   end

   // palette limit and the texel at the head of the word
   always_comb begin
      limit = (entries_ff > DEPTH9) ? DEPTH9 : entries_ff;
      if (bpp_sel == 3'd0 && limit > 9'd16) begin
         limit = 9'd16;
      end
      tidx = (bpp_sel == 3'd0) ? {4'b0000, word_ff[31:28]} : word_ff[31:24];
      s1_in.fmt = fmt_ff;
      s1_in.bad = indexed && ({1'b0, tidx} >= limit);
      case (bpp_sel)
         3'd0: s1_in.texel = {28'd0, word_ff[31:28]};
         3'd1: s1_in.texel = {24'd0, word_ff[31:24]};
         3'd2: s1_in.texel = {16'd0, word_ff[31:16]};
         default: s1_in.texel = word_ff;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      word_in = word_ff;
      cnt_in  = cnt_ff;
      eoi_in  = eoi_ff;
      if (issue) begin
         cnt_in = cnt_ff - 4'd1;
         case (bpp_sel)
            3'd0: word_in = {word_ff[27:0], 4'd0};
            3'd1: word_in = {word_ff[23:0], 8'd0};
            3'd2: word_in = {word_ff[15:0], 16'd0};
            default: word_in = 32'd0;
         endcase
         if (cnt_ff == 4'd1) begin
            busy_in = 1'b0;
         end
      end
      if (accept && req_data.command == tt2r_pkg::CMD_DECODE_WORD) begin
         busy_in = fmt_ok && (cnt_load != 4'd0);
         word_in = req_data.pixel_word;
         cnt_in  = cnt_load;
         eoi_in  = req_data.end_of_image;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff     <= tt2r_pkg::FMT_RGBA32;
         entries_ff <= 9'd256;
      end else if (csr_wr_en) begin
         case (csr_index)
            tt2r_pkg::CSR_TEXTURE_FORMAT:  fmt_ff     <= csr_wr_data[3:0];
            tt2r_pkg::CSR_PALETTE_ENTRIES: entries_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= 4'd0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         if (adv) begin
            s1_valid_ff  <= busy_ff;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
      word_ff <= word_in;
      eoi_ff  <= eoi_in;
      if (adv) begin
         s1_ff      <= s1_in;
         s1_last_ff <= (cnt_ff == 4'd1);
         s1_done_ff <= (cnt_ff == 4'd1) && eoi_ff;
         rsp_ff.rgba_color   <= rgba;
         rsp_ff.bad_index    <= s1_ff.bad;
         rsp_ff.last_of_word <= s1_last_ff;
         rsp_ff.image_done   <= s1_done_ff;
      end
   end

   // palette: a write is taken only once the word ahead has issued its
   // last read, so a same-edge read must see the old entry
   always_ff @(posedge clock) begin
      if (accept && req_data.command == tt2r_pkg::CMD_PALETTE_WRITE &&
          {1'b0, req_data.palette_index} < DEPTH9) begin
         palette_mem[req_data.palette_index[PAW-1:0]] <= req_data.palette_color;
      end
      if (adv) begin
         rd_ff <= palette_mem[tidx[PAW-1:0]];
      end
   end

   tt2r_convert u_convert (
      .s       (s1_ff),
      .palette (rd_ff),
      .rgba    (rgba)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TT2R_ASSERT_IMP(a_busy_has_texels, busy_ff, cnt_ff != 4'd0)
   `TT2R_ASSERT_IMP(a_accept_only_at_end, accept && busy_ff, last_issue)
   `TT2R_ASSERT_NEXT(a_word_stays, issue && cnt_ff > 4'd1, busy_ff)
   `TT2R_ASSERT_IMP(a_bad_only_indexed, s1_valid_ff && s1_ff.bad,
                    s1_ff.fmt >= tt2r_pkg::FMT_CI4_RGBA16)
   `TT2R_ASSERT_IMP(a_done_on_last, rsp_valid_ff && rsp_ff.image_done,
                    rsp_ff.last_of_word)

endmodule

// ===== src/tt2r_convert.sv =====
// ----------------------------------------------------------------------------
// tt2r_convert
// Expands one texel, or the palette entry it selects, to an RGBA32 pixel.
// ----------------------------------------------------------------------------
module tt2r_convert (
   input  tt2r_pkg::texel_type s,
   input  logic [15:0]         palette,
   output logic [31:0]         rgba
);

   // (v * 255) / 31 via reciprocal and one correction step
   function automatic logic [7:0] scale5(input logic [4:0] v);
      logic [7:0]  y;
      logic [13:0] p;
      logic [2:0]  q;
      logic [7:0]  r;
      y = 8'({3'b000, v} * 8'd7);
      p = 14'({6'b000000, y} * 14'd33);
      q = p[12:10];
      r = y - 8'({5'b00000, q} * 8'd31);
      if (r >= 8'd31) begin
         q = q + 3'd1;
      end
      return {v, 3'b000} + {5'b00000, q};
   endfunction

   // (v * 255) / 7
   function automatic logic [7:0] scale3(input logic [2:0] v);
      logic [7:0] res;
      case (v)
         3'd0: res = 8'd0;
         3'd1: res = 8'd36;
         3'd2: res = 8'd72;
         3'd3: res = 8'd109;
         3'd4: res = 8'd145;
         3'd5: res = 8'd182;
         3'd6: res = 8'd218;
         default: res = 8'd255;
      endcase
      return res;
   endfunction

   function automatic logic [31:0] pack_i(input logic [7:0] i, input logic [7:0] a);
      return {i, i, i, a};
   endfunction

   function automatic logic [31:0] from_rgba16(input logic [15:0] c);
      return {scale5(c[15:11]), scale5(c[10:6]), scale5(c[5:1]), {8{c[0]}}};
   endfunction

   function automatic logic [31:0] from_ia16(input logic [15:0] c);
      return pack_i(c[15:8], c[7:0]);
   endfunction

   always_comb begin
      case (s.fmt)
         tt2r_pkg::FMT_I4: begin
            rgba = pack_i({s.texel[3:0], s.texel[3:0]}, 8'hFF);
         end
         tt2r_pkg::FMT_IA4: begin
            rgba = pack_i(scale3(s.texel[3:1]), {8{s.texel[0]}});
         end
         tt2r_pkg::FMT_I8: begin
            rgba = pack_i(s.texel[7:0], 8'hFF);
         end
         tt2r_pkg::FMT_IA8: begin
            rgba = pack_i({s.texel[7:4], s.texel[7:4]}, {s.texel[3:0], s.texel[3:0]});
         end
         tt2r_pkg::FMT_IA16: begin
            rgba = from_ia16(s.texel[15:0]);
         end
         tt2r_pkg::FMT_RGBA16: begin
            rgba = from_rgba16(s.texel[15:0]);
         end
         tt2r_pkg::FMT_RGBA32: begin
            rgba = s.texel;
         end
         tt2r_pkg::FMT_CI4_RGBA16, tt2r_pkg::FMT_CI8_RGBA16: begin
            rgba = s.bad ? 32'd0 : from_rgba16(palette);
         end
         tt2r_pkg::FMT_CI4_IA16, tt2r_pkg::FMT_CI8_IA16: begin
            rgba = s.bad ? 32'd0 : from_ia16(palette);
         end
         default: begin
            rgba = 32'd0;
         end
      endcase
   end

endmodule
